@@ sv/kvt_pkg.sv @@
// Shared package for the keyed value table: sizes, field widths, request and
// status codes, controller states and the controller/datapath command structs.
// No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int FIELD_W   = 32;
    localparam int MATCH_W   = 6;
    localparam int OCC_W     = 6;

    localparam int IN_TDATA_W  = 2 * FIELD_W;
    localparam int OUT_BITS    = FIELD_W + MATCH_W + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [MATCH_W-1:0]    t_match;
    typedef logic [OCC_W-1:0]      t_occ;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [IDX_W-1:0]      t_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_ERASE  = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_COUNT  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_RDLAST,
        S_MOVE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic append;
        logic rd_last;
        logic move;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  hit;
        logic  scan_done;
        logic  out_busy;
    } t_dp_sts;

endpackage

@@ sv/kvt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/kvt_ctrl.sv @@
// Request sequencer for the keyed value table: scan, append, move-last, finish.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kvt_pkg::t_dp_sts  i_sts,
    output kvt_pkg::t_dp_cmd  o_cmd
);

    kvt_pkg::t_state r_state;
    kvt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            kvt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = kvt_pkg::S_SCAN;
                end
            end
            kvt_pkg::S_SCAN: begin
                if (i_sts.kind == kvt_pkg::KIND_INSERT && i_sts.full) begin
                    n_state = kvt_pkg::S_FINISH;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_sts.scan_done) begin
                        unique case (i_sts.kind)
                            kvt_pkg::KIND_INSERT:
                                n_state = i_sts.hit ? kvt_pkg::S_FINISH : kvt_pkg::S_APPEND;
                            kvt_pkg::KIND_ERASE:
                                n_state = i_sts.hit ? kvt_pkg::S_RDLAST : kvt_pkg::S_FINISH;
                            default:
                                n_state = kvt_pkg::S_FINISH;
                        endcase
                    end
                end
            end
            kvt_pkg::S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = kvt_pkg::S_FINISH;
            end
            kvt_pkg::S_RDLAST: begin
                o_cmd.rd_last = 1'b1;
                n_state       = kvt_pkg::S_MOVE;
            end
            kvt_pkg::S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = kvt_pkg::S_FINISH;
            end
            kvt_pkg::S_FINISH: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = kvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kvt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/kvt_dp.sv @@
// Datapath for the keyed value table: key and value RAMs, scan pipeline,
// occupancy counter and result register. Depends on kvt_pkg and kvt_ram.
`timescale 1ns / 1ps

module kvt_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kvt_pkg::t_dp_cmd              i_cmd,
    output kvt_pkg::t_dp_sts              o_sts,
    input  logic [kvt_pkg::KIND_W-1:0]    i_kind,
    input  logic [kvt_pkg::FIELD_W-1:0]   i_key,
    input  logic [kvt_pkg::FIELD_W-1:0]   i_value,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [kvt_pkg::STATUS_W-1:0]  o_status,
    output logic [kvt_pkg::FIELD_W-1:0]   o_value_out,
    output logic [kvt_pkg::MATCH_W-1:0]   o_match_count,
    output logic [kvt_pkg::OCC_W-1:0]     o_occupancy
);

    kvt_pkg::t_kind   r_kind;
    kvt_pkg::t_key    r_key;
    kvt_pkg::t_val    r_value;
    kvt_pkg::t_cnt    r_count;
    kvt_pkg::t_cnt    r_idx;
    logic             r_pend;
    kvt_pkg::t_idx    r_pend_idx;
    logic             r_hit;
    kvt_pkg::t_idx    r_slot;
    kvt_pkg::t_val    r_found;
    kvt_pkg::t_cnt    r_match;
    logic             r_full;

    logic             r_out_valid;
    kvt_pkg::t_status r_status;
    kvt_pkg::t_field  r_value_out;
    kvt_pkg::t_match  r_match_out;
    kvt_pkg::t_occ    r_occ_out;

    kvt_pkg::t_key    key_rd;
    kvt_pkg::t_val    val_rd;
    kvt_pkg::t_cnt    last_idx;
    kvt_pkg::t_idx    raddr;
    kvt_pkg::t_idx    waddr;
    kvt_pkg::t_key    key_wdata;
    kvt_pkg::t_val    val_wdata;
    logic             we;
    logic             key_hit;
    logic             val_hit;
    logic             issue;
    kvt_pkg::t_status n_status;
    kvt_pkg::t_field  n_value_out;

    assign last_idx  = r_count - kvt_pkg::t_cnt'(1);
    assign raddr     = i_cmd.rd_last ? last_idx[kvt_pkg::IDX_W-1:0] : r_idx[kvt_pkg::IDX_W-1:0];
    assign we        = i_cmd.append | i_cmd.move;
    assign waddr     = i_cmd.move ? r_slot : r_count[kvt_pkg::IDX_W-1:0];
    assign key_wdata = i_cmd.move ? key_rd : r_key;
    assign val_wdata = i_cmd.move ? val_rd : r_value;

    kvt_ram #(
        .WIDTH (kvt_pkg::KEY_BITS),
        .DEPTH (kvt_pkg::TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (key_rd)
    );

    kvt_ram #(
        .WIDTH (kvt_pkg::VALUE_BITS),
        .DEPTH (kvt_pkg::TABLE_DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (val_wdata),
        .i_raddr (raddr),
        .o_rdata (val_rd)
    );

    // one read issued per cycle, compared when the registered data returns
    assign key_hit = r_pend && (r_kind != kvt_pkg::KIND_COUNT) && (key_rd == r_key);
    assign val_hit = r_pend && (r_kind == kvt_pkg::KIND_COUNT) && (val_rd == r_value);
    assign issue   = i_cmd.scan && (r_idx < r_count) && !r_hit && !key_hit;

    always_comb begin
        n_status    = kvt_pkg::ST_OK;
        n_value_out = '0;
        unique case (r_kind)
            kvt_pkg::KIND_INSERT: begin
                if (r_full) begin
                    n_status = kvt_pkg::ST_FULL;
                end else if (r_hit) begin
                    n_status = kvt_pkg::ST_DUP;
                end
            end
            kvt_pkg::KIND_ERASE: begin
                if (!r_hit) begin
                    n_status = kvt_pkg::ST_MISSING;
                end
            end
            kvt_pkg::KIND_LOOKUP: begin
                if (r_hit) begin
                    n_value_out = kvt_pkg::t_field'(r_found);
                end else begin
                    n_status = kvt_pkg::ST_MISSING;
                end
            end
            default: begin
                n_status = kvt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= issue;
            end
            if (i_cmd.append) begin
                r_count <= r_count + kvt_pkg::t_cnt'(1);
            end else if (i_cmd.move) begin
                r_count <= last_idx;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= kvt_pkg::t_kind'(i_kind);
            r_key   <= kvt_pkg::t_key'(i_key);
            r_value <= kvt_pkg::t_val'(i_value);
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_match <= '0;
            r_full  <= (r_count == kvt_pkg::t_cnt'(kvt_pkg::TABLE_DEPTH));
        end else if (i_cmd.scan) begin
            if (issue) begin
                r_idx      <= r_idx + kvt_pkg::t_cnt'(1);
                r_pend_idx <= r_idx[kvt_pkg::IDX_W-1:0];
            end
            if (key_hit) begin
                r_hit   <= 1'b1;
                r_slot  <= r_pend_idx;
                r_found <= val_rd;
            end
            if (val_hit) begin
                r_match <= r_match + kvt_pkg::t_cnt'(1);
            end
        end
        if (i_cmd.finish) begin
            r_status    <= n_status;
            r_value_out <= n_value_out;
            r_match_out <= (r_kind == kvt_pkg::KIND_COUNT) ? kvt_pkg::t_match'(r_match) : '0;
            r_occ_out   <= kvt_pkg::t_occ'(r_count);
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.full      = r_full;
    assign o_sts.hit       = r_hit;
    assign o_sts.scan_done = (r_hit || (r_idx >= r_count)) && !r_pend;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_value_out   = r_value_out;
    assign o_match_count = r_match_out;
    assign o_occupancy   = r_occ_out;

endmodule

@@ sv/keyed_value_table.sv @@
// Keyed value table: unsorted key/value map, one request at a time.
// Steps: load the request, scan the stored entries until a key hit or the end (skipped on an
// insert into a full table), append on a miss insert, or read the last entry and move it into
// the erased slot on an erase hit, then finish. A new request is accepted only after the last
// one finishes, and finish waits while an earlier result is still waiting on m_axis_tready.
// Synchronous active-low reset empties the table; RAM contents are not cleared.
`timescale 1ns / 1ps

module keyed_value_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [kvt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // key[31:0], value[63:32]
    input  logic [kvt_pkg::KIND_W-1:0]        s_axis_tuser,  // kind[1:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [kvt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // value_out[31:0],
                                                             // match_count[37:32],
                                                             // occupancy[43:38], zeros
    output logic [kvt_pkg::STATUS_W-1:0]      m_axis_tuser   // status[1:0]
);

    kvt_pkg::t_dp_cmd cmd;
    kvt_pkg::t_dp_sts sts;

    logic [kvt_pkg::FIELD_W-1:0] value_out;
    logic [kvt_pkg::MATCH_W-1:0] match_count;
    logic [kvt_pkg::OCC_W-1:0]   occupancy;

    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kvt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (s_axis_tuser),
        .i_key         (s_axis_tdata[kvt_pkg::FIELD_W-1:0]),
        .i_value       (s_axis_tdata[kvt_pkg::IN_TDATA_W-1:kvt_pkg::FIELD_W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (m_axis_tuser),
        .o_value_out   (value_out),
        .o_match_count (match_count),
        .o_occupancy   (occupancy)
    );

    assign m_axis_tdata = {{kvt_pkg::OUT_PAD_W{1'b0}}, occupancy, match_count, value_out};

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    a_full_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == kvt_pkg::ST_FULL
            |-> occupancy == kvt_pkg::t_occ'(kvt_pkg::TABLE_DEPTH))
        else $error("full status with table not full");

    a_payload_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (value_out != '0 || match_count != '0)
            |-> m_axis_tuser == kvt_pkg::ST_OK)
        else $error("result payload set on a failed request");

endmodule

@@ sim/tb_keyed_value_table.sv @@
// Self-checking testbench for keyed_value_table: directed and random requests over the
// slave stream, in-order prediction of every result, field-by-field compare on the master side.
// Depends on kvt_pkg and keyed_value_table.
`timescale 1ns / 1ps

module tb_keyed_value_table;

    import kvt_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int KEY_POOL    = 48;
    localparam int VAL_POOL    = 6;

    typedef struct {
        t_status status;
        t_field  value_out;
        t_match  match_count;
        t_occ    occupancy;
    } t_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    // shadow copy of the table
    t_key    shadow_key [TABLE_DEPTH];
    t_val    shadow_val [TABLE_DEPTH];
    int      shadow_used = 0;

    t_result pending_results[$];
    t_key    key_pool [KEY_POOL];
    t_val    val_pool [VAL_POOL];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      stall_left     = 0;
    bit      no_idle        = 1'b0;

    keyed_value_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int slot_of(t_key key);
        for (int i = 0; i < shadow_used; i++) begin
            if (shadow_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic t_result table_predict(t_kind kind, t_key key, t_val value);
        t_result r;
        int      slot;
        r.status      = ST_OK;
        r.value_out   = '0;
        r.match_count = '0;
        slot = slot_of(key);
        case (kind)
            KIND_INSERT: begin
                if (shadow_used >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else if (slot >= 0) begin
                    r.status = ST_DUP;
                end else begin
                    shadow_key[shadow_used] = key;
                    shadow_val[shadow_used] = value;
                    shadow_used++;
                end
            end
            KIND_ERASE: begin
                if (slot < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    shadow_used--;
                    shadow_key[slot] = shadow_key[shadow_used];
                    shadow_val[slot] = shadow_val[shadow_used];
                end
            end
            KIND_LOOKUP: begin
                if (slot < 0) r.status = ST_MISSING;
                else r.value_out = shadow_val[slot];
            end
            default: begin
                for (int i = 0; i < shadow_used; i++) begin
                    if (shadow_val[i] == value) r.match_count++;
                end
            end
        endcase
        r.occupancy = t_occ'(shadow_used);
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 70);
    endfunction

    task automatic send_request(t_kind kind, t_key key, t_val value);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(table_predict(kind, key, value));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic t_key pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60 && shadow_used > 0) return shadow_key[$urandom_range(0, shadow_used - 1)];
        if (r < 90) return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return $urandom;
    endfunction

    function automatic t_val pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return val_pool[$urandom_range(0, VAL_POOL - 1)];
        if (r < 60) return $urandom_range(0, 1) ? '1 : '0;
        return $urandom;
    endfunction

    function automatic t_key fresh_key();
        t_key key;
        do key = $urandom; while (slot_of(key) >= 0);
        return key;
    endfunction

    task automatic test_empty_table();
        send_request(KIND_LOOKUP, '1, '0);
        send_request(KIND_ERASE, '0, '1);
        send_request(KIND_COUNT, '0, '0);
    endtask

    task automatic test_basic_ops();
        send_request(KIND_INSERT, '0, '0);
        send_request(KIND_INSERT, '1, '1);
        send_request(KIND_INSERT, '0, 32'h5);
        send_request(KIND_LOOKUP, '0, '1);
        send_request(KIND_LOOKUP, '1, '0);
        send_request(KIND_LOOKUP, 32'h1234_5678, '0);
        send_request(KIND_COUNT, '1, '1);
        send_request(KIND_INSERT, 32'hA5A5_A5A5, '0);
        send_request(KIND_COUNT, '1, '0);
        send_request(KIND_COUNT, '0, 32'h5A5A_5A5A);
        send_request(KIND_ERASE, '0, '0);
        send_request(KIND_LOOKUP, 32'hA5A5_A5A5, '0);
        send_request(KIND_ERASE, '1, '0);
        send_request(KIND_ERASE, '1, '0);
        send_request(KIND_ERASE, 32'hA5A5_A5A5, '0);
        send_request(KIND_LOOKUP, 32'hA5A5_A5A5, '0);
    endtask

    task automatic test_full_table();
        t_val shared;
        t_key some_key;
        shared = $urandom;
        while (shadow_used < TABLE_DEPTH) begin
            send_request(KIND_INSERT, fresh_key(), shared);
        end
        send_request(KIND_COUNT, '0, shared);
        send_request(KIND_INSERT, fresh_key(), $urandom);
        // full wins over duplicate
        send_request(KIND_INSERT, shadow_key[$urandom_range(0, TABLE_DEPTH - 1)], '0);
        send_request(KIND_LOOKUP, shadow_key[TABLE_DEPTH - 1], '0);
        send_request(KIND_ERASE, shadow_key[0], '0);
        send_request(KIND_ERASE, shadow_key[shadow_used - 1], '0);
        send_request(KIND_INSERT, fresh_key(), '1);
        send_request(KIND_INSERT, fresh_key(), '0);
        send_request(KIND_INSERT, fresh_key(), '0);
        wait_drained();
        while (shadow_used > 0) begin
            some_key = shadow_key[$urandom_range(0, shadow_used - 1)];
            send_request(KIND_ERASE, some_key, $urandom);
            if ($urandom_range(0, 3) == 0) send_request(KIND_LOOKUP, some_key, '0);
        end
        send_request(KIND_COUNT, '0, shared);
    endtask

    task automatic test_random_traffic(int n);
        t_kind kind;
        t_val  value;
        int    r;
        bit    filling;
        filling = 1'b1;
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) filling = $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (filling) begin
                if (r < 55) kind = KIND_INSERT;
                else if (r < 70) kind = KIND_ERASE;
                else if (r < 88) kind = KIND_LOOKUP;
                else kind = KIND_COUNT;
            end else begin
                if (r < 15) kind = KIND_INSERT;
                else if (r < 60) kind = KIND_ERASE;
                else if (r < 85) kind = KIND_LOOKUP;
                else kind = KIND_COUNT;
            end
            value = pick_value();
            if (kind == KIND_COUNT && shadow_used > 0 && $urandom_range(0, 3) != 0) begin
                value = shadow_val[$urandom_range(0, shadow_used - 1)];
            end
            send_request(kind, pick_key(), value);
        end
    endtask

    task automatic test_back_to_back(int n);
        no_idle = 1'b1;
        test_random_traffic(n);
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_INSERT;
        for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 0; i < VAL_POOL; i++) val_pool[i] = $urandom;
        val_pool[0] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_basic_ops();
        test_full_table();
        test_random_traffic(450);
        wait_drained();
        test_back_to_back(250);
        test_random_traffic(450);

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left <= idle_len();
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0h/%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_axis_tuser));
                check_field("value_out", want.value_out, m_axis_tdata[31:0]);
                check_field("match_count", 32'(want.match_count), 32'(m_axis_tdata[37:32]));
                check_field("occupancy", 32'(want.occupancy), 32'(m_axis_tdata[43:38]));
                check_field("padding", '0, 32'(m_axis_tdata[OUT_TDATA_W-1:OUT_BITS]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d transactions outstanding", $time,
                     pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
